// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on each rising edge, disabled in reset
`define OSTT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("ostt check failed");
`endif

// ===== sv/ostt_pkg.sv =====
`timescale 1ns / 1ps
package ostt_pkg;
   localparam int NUM_SLOTS_DEF = 16;
   localparam logic [31:0] SIGN32 = 32'h8000_0000;

   localparam logic [1:0] F_TICK   = 2'd0;
   localparam logic [1:0] F_ARM    = 2'd1;
   localparam logic [1:0] F_CANCEL = 2'd2;
   localparam logic [1:0] F_NONE   = 2'd3;

   localparam logic [2:0] K_ARM_OK    = 3'd0;
   localparam logic [2:0] K_ARM_FULL  = 3'd1;
   localparam logic [2:0] K_CAN_OK    = 3'd2;
   localparam logic [2:0] K_CAN_NF    = 3'd3;
   localparam logic [2:0] K_EXPIRED   = 3'd4;
   localparam logic [2:0] K_TICK_DONE = 3'd5;

   typedef struct packed {
      logic [1:0]  func;
      logic [30:0] delay_ticks;
      logic [31:0] user_tag;
      logic [31:0] timer_id;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        result_id;
      logic [31:0]        result_tag;
      logic signed [31:0] time_to_next;
      logic               last;
   } rsp_type;

   // one timer slot as it travels round the ring
   typedef struct packed {
      logic        valid;
      logic        expired;
      logic [31:0] id;
      logic [31:0] deadline;
      logic [31:0] tag;
   } slot_type;
endpackage

// ===== sv/ostt_cell.sv =====
`timescale 1ns / 1ps
module ostt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  ostt_pkg::slot_type din,
   output ostt_pkg::slot_type dout
);
   import ostt_pkg::*;

   logic        valid_ff, expired_ff;
   logic [31:0] id_ff, deadline_ff, tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         expired_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff   <= din.valid;
         expired_ff <= din.expired;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         id_ff       <= din.id;
         deadline_ff <= din.deadline;
         tag_ff      <= din.tag;
      end
   end

   assign dout = '{valid: valid_ff, expired: expired_ff, id: id_ff,
                   deadline: deadline_ff, tag: tag_ff};
endmodule

// ===== sv/one_shot_timer_table_core.sv =====
`timescale 1ns / 1ps
// Channel    Handshake              Payload
// request    start / busy           req_data  (func, delay, tag, id)
// response   rsp_strobe (1 cycle)   rsp_data  (kind, id, tag, time_to_next, last)
//
// Arm and cancel make a scan lap of the slot ring, then respond.
// Tick makes a scan lap, then an emit lap in which the expiries come out.
// Laps are paced by the slot ring, which moves one slot past the
// head unit each cycle of a lap. Func 3 is dropped without going busy.
// Reset clears all slot valid bits, now and sets next id to 1.
// Responses cannot be held off; the output register frees the core, so the
// next request may be accepted while the final response is on the port.
module one_shot_timer_table_core #(
   parameter int NUM_SLOTS = ostt_pkg::NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ostt_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ostt_pkg::rsp_type rsp_data
);
   import ostt_pkg::*;

   localparam int CW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [CW-1:0] LAST_STEP = CW'(NUM_SLOTS - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_EMIT = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    func_ff;
   logic [30:0]   delay_ff;
   logic [31:0]   tag_ff, tid_ff;
   logic [31:0]   now_ff, now_in, next_id_ff, next_id_in;
   logic [31:0]   new_id_ff, new_id_in;
   logic          hit_ff, hit_in;
   logic          any_ff, any_in;
   logic [31:0]   best_ff, best_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   slot_type ring [NUM_SLOTS];
   slot_type head, wb;
   logic     shift_en;

   // ring: each cell takes its upper neighbour, the tail takes the write-back
   genvar gi;
   generate
      for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
         if (gi == NUM_SLOTS - 1) begin : g_tail
            ostt_cell u_cell (.clock(clock), .reset(reset), .shift_en(shift_en),
                              .din(wb), .dout(ring[gi]));
         end else begin : g_body
            ostt_cell u_cell (.clock(clock), .reset(reset), .shift_en(shift_en),
                              .din(ring[gi+1]), .dout(ring[gi]));
         end
      end
   endgenerate

   assign head     = ring[0];
   assign shift_en = (state_ff == S_SCAN) || (state_ff == S_EMIT);

   logic          accept;
   logic [31:0]   diff, key, ttn;
   logic          cur_any, fresh;
   logic [31:0]   head_diff;

   assign accept    = start && (state_ff == S_IDLE);
   assign head_diff = head.deadline - now_ff;

   always_comb begin
      ttn = !any_ff ? 32'hFFFF_FFFF : ((best_ff <= SIGN32) ? 32'd0 : (best_ff ^ SIGN32));
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      now_in        = now_ff;
      next_id_in    = next_id_ff;
      new_id_in     = new_id_ff;
      hit_in        = hit_ff;
      any_in        = any_ff;
      best_in       = best_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wb            = head;
      fresh         = 1'b0;
      diff          = head_diff;
      cur_any       = any_ff;
      key           = '0;

      case (state_ff)
         S_IDLE: begin
            if (start && req_data.func != F_NONE) begin
               state_in = S_SCAN;
               cnt_in   = '0;
               hit_in   = 1'b0;
               if (req_data.func == F_TICK) now_in = now_ff + 32'd1;
            end
         end
         S_SCAN: begin
            case (func_ff)
               F_ARM: begin
                  if (!hit_ff && !head.valid) begin
                     wb = '{valid: 1'b1, expired: 1'b0, id: next_id_ff,
                            deadline: now_ff + {1'b0, delay_ff}, tag: tag_ff};
                     fresh     = 1'b1;
                     hit_in    = 1'b1;
                     new_id_in = next_id_ff;
                     next_id_in = (next_id_ff == 32'hFFFF_FFFF) ? 32'd1
                                                                : next_id_ff + 32'd1;
                  end
               end
               F_CANCEL: begin
                  if (tid_ff != '0 && !hit_ff && head.valid && head.id == tid_ff) begin
                     wb.valid = 1'b0;
                     hit_in   = 1'b1;
                  end
               end
               default: begin
                  // tick: due when deadline - now is zero or negative
                  if (head.valid && (head_diff == '0 || head_diff[31])) begin
                     wb.valid   = 1'b0;
                     wb.expired = 1'b1;
                  end
               end
            endcase
            // running minimum over the slots as they leave the head unit
            if (fresh) diff = {1'b0, delay_ff};
            key     = diff ^ SIGN32;
            cur_any = (cnt_ff == '0) ? 1'b0 : any_ff;
            if (wb.valid) begin
               if (!cur_any || key < best_ff) best_in = key;
               any_in = 1'b1;
            end else begin
               any_in = cur_any;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cnt_in   = '0;
               state_in = (func_ff == F_TICK) ? S_EMIT : S_DONE;
            end
         end
         S_EMIT: begin
            wb.expired = 1'b0;
            if (head.expired) begin
               rsp_strobe_in = 1'b1;
               rsp_in = '{kind: K_EXPIRED, result_id: head.id, result_tag: head.tag,
                          time_to_next: ttn, last: 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_in = '{kind: K_TICK_DONE, result_id: '0, result_tag: '0,
                       time_to_next: ttn, last: 1'b1};
            if (func_ff == F_ARM) begin
               rsp_in.kind      = hit_ff ? K_ARM_OK : K_ARM_FULL;
               rsp_in.result_id = hit_ff ? new_id_ff : '0;
            end else if (func_ff == F_CANCEL) begin
               rsp_in.kind = (hit_ff || tid_ff == '0) ? K_CAN_OK : K_CAN_NF;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         now_ff        <= '0;
         next_id_ff    <= 32'd1;
         hit_ff        <= 1'b0;
         any_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         now_ff        <= now_in;
         next_id_ff    <= next_id_in;
         hit_ff        <= hit_in;
         any_ff        <= any_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_data.func;
         delay_ff <= req_data.delay_ticks;
         tag_ff   <= req_data.user_tag;
         tid_ff   <= req_data.timer_id;
      end
      new_id_ff <= new_id_in;
      best_ff   <= best_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
endmodule

// ===== sv/ostt_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ostt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input ostt_pkg::req_type req_data,
   input logic              rsp_strobe,
   input ostt_pkg::rsp_type rsp_data
);
   import ostt_pkg::*;

   `OSTT_ASSERT(a_goes_busy, clock, reset, start && !busy && req_data.func != F_NONE |=> busy)
   `OSTT_ASSERT(a_expiry_not_last, clock, reset, rsp_strobe && rsp_data.kind == K_EXPIRED |-> !rsp_data.last)
   `OSTT_ASSERT(a_single_is_last, clock, reset, rsp_strobe && rsp_data.kind != K_EXPIRED |-> rsp_data.last)
   `OSTT_ASSERT(a_ttn_range, clock, reset, rsp_strobe |-> rsp_data.time_to_next >= -32'sd1)
endmodule

bind one_shot_timer_table_core ostt_checker u_ostt_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
);
